[rtl/gthd_pkg.sv]
package gthd_pkg;

	// field widths
	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int RADIUS_W = 23;
	localparam int DIST_W   = 31;

	// fixed point format of angles, sines and cosines
	localparam int ANGLE_FRAC_BITS = 30;
	localparam int CORDIC_ITERATIONS = 32;
	// width of the cordic x, y and z registers, covers reduced angles and vector gain
	localparam int CORDIC_W = 36;

	// pi and gain with 60 fraction bits
	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
	localparam logic [63:0] GAIN_Q60   = 64'd700114967507363238;
	// radians per degree*1e7, 60 fraction bits
	localparam logic [63:0] DEG_E7_Q60 = (PI_Q60 + 64'd900000000) / 64'd1800000000;

	localparam logic signed [CORDIC_W-1:0] PI_F = CORDIC_W'(
		(PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
	localparam logic signed [CORDIC_W-1:0] HPI_F = CORDIC_W'(
		(PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));
	localparam logic signed [CORDIC_W-1:0] TPI_F = CORDIC_W'(
		(PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS));
	localparam logic signed [CORDIC_W-1:0] GAIN_F = CORDIC_W'(
		(GAIN_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
	localparam logic [ANGLE_FRAC_BITS:0] ONE_F = {1'b1, {ANGLE_FRAC_BITS{1'b0}}};

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
	localparam logic [DIST_W-1:0]   DIST_MAX     = 31'd2010619298;

	// arctangent of 2^-i, rounded to 30 fraction bits
	function automatic logic [31:0] atan_f(input logic [5:0] idx);
		logic [31:0] v;
		case (idx)
			6'd0:    v = 32'd843314857;
			6'd1:    v = 32'd497837829;
			6'd2:    v = 32'd263043837;
			6'd3:    v = 32'd133525159;
			6'd4:    v = 32'd67021687;
			6'd5:    v = 32'd33543516;
			6'd6:    v = 32'd16775851;
			6'd7:    v = 32'd8388437;
			6'd8:    v = 32'd4194283;
			6'd9:    v = 32'd2097149;
			6'd30:   v = 32'd1;
			6'd31:   v = 32'd1;
			default: begin
				if (idx < 6'd30) begin
					v = 32'd1 << (6'd30 - idx);
				end else begin
					v = 32'd0;
				end
			end
		endcase
		return v;
	endfunction

endpackage

[rtl/gps_track_haversine_distance.sv]
// a fix without history goes straight to the output beat, else the block computes the distance
// to the previous fix and then, once two fixes are held, the distance to the fix two back;
// one fix is in work at a time
// the work runs on the shared cordic, square root and 32x32 multiplier steps
// arst_n clears the fix count, so stale history is never used, and the output beat;
// radius resets to 6371000 m
module gps_track_haversine_distance #(
	parameter int CORDIC_ITERATIONS = gthd_pkg::CORDIC_ITERATIONS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fix_valid,
	output logic                                fix_ready,
	input  logic signed [gthd_pkg::LAT_W-1:0]   lat_e7,
	input  logic signed [gthd_pkg::LON_W-1:0]   lon_e7,
	input  logic                                cfg_wr_en,
	input  logic [gthd_pkg::RADIUS_W-1:0]       cfg_wr_data,
	output logic                                dist_valid,
	input  logic                                dist_ready,
	output logic [gthd_pkg::DIST_W-1:0]         dist_prev_cm,
	output logic                                dist_prev_valid,
	output logic [gthd_pkg::DIST_W-1:0]         dist_two_back_cm,
	output logic                                dist_two_back_valid
);

	localparam int CW  = gthd_pkg::CORDIC_W;
	localparam int AFB = gthd_pkg::ANGLE_FRAC_BITS;
	localparam int ITW = $clog2(CORDIC_ITERATIONS + 1);
	localparam int RW  = 65 - AFB;
	localparam int DW  = gthd_pkg::DIST_W;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RAD   = 9'b000000010,
		ST_ROT   = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_ACC   = 9'b000010000,
		ST_SQRT  = 9'b000100000,
		ST_VEC   = 9'b001000000,
		ST_SCALE = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] m;
		m = v[CW-1] ? -v : v;
		return m[31:0];
	endfunction

	state_t                       state_q;
	logic [ITW-1:0]               it_q;
	logic [1:0]                   job_q;
	logic                         pass_q;
	logic                         has_prev_q;
	logic                         has_two_q;
	logic [1:0]                   seen_q;
	logic [gthd_pkg::RADIUS_W-1:0] radius_q;

	logic signed [gthd_pkg::LAT_W-1:0] cur_lat_q, last_lat_q, older_lat_q;
	logic signed [gthd_pkg::LON_W-1:0] cur_lon_q, last_lon_q, older_lon_q;

	logic [63:0]          prod_q;
	logic                 msign_q;
	logic                 rneg_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic signed [CW-1:0] c1_q, c2_q, sd_q, sl_q;
	logic signed [CW-1:0] sdsd_q, slsl_q, c12_q, term_q;
	logic [AFB:0]         a_q;
	logic [62:0]          sq_n_q, sq_r_q, sq_b_q;
	logic [31:0]          sa_q;
	logic [DW-1:0]        dprev_q, dtwo_q;

	logic                 dist_valid_q;
	logic [DW-1:0]        dist_prev_cm_q, dist_two_back_cm_q;
	logic                 dist_prev_valid_q, dist_two_back_valid_q;

	// first fix of the current pair
	logic signed [gthd_pkg::LAT_W-1:0] lat1;
	logic signed [gthd_pkg::LON_W-1:0] lon1;
	assign lat1 = pass_q ? older_lat_q : last_lat_q;
	assign lon1 = pass_q ? older_lon_q : last_lon_q;

	// angle source for degree to radian conversion
	logic signed [32:0] rad_src;
	logic               rad_neg;
	logic [31:0]        rad_mag;
	logic [32:0]        rad_neg_src;
	always_comb begin
		case (job_q)
			2'd0:    rad_src = 33'(lat1);
			2'd1:    rad_src = 33'(cur_lat_q);
			2'd2:    rad_src = 33'(cur_lat_q) - 33'(lat1);
			default: rad_src = 33'(cur_lon_q) - 33'(lon1);
		endcase
	end
	assign rad_neg     = rad_src[32];
	assign rad_neg_src = -rad_src;
	assign rad_mag     = rad_neg ? rad_neg_src[31:0] : rad_src[31:0];

	// radius times 200 gives centimetres per radian/2
	logic [30:0] r200;
	assign r200 = (31'(radius_q) << 7) + (31'(radius_q) << 6) + (31'(radius_q) << 3);

	// shared 32x32 multiplier operands
	logic [31:0] mul_a, mul_b;
	logic        mul_neg;
	logic [63:0] prod_d;
	always_comb begin
		mul_a   = rad_mag;
		mul_b   = gthd_pkg::DEG_E7_Q60[31:0];
		mul_neg = rad_neg;
		case (state_q)
			ST_MUL: begin
				case (job_q)
					2'd0: begin
						mul_a   = mag32(sd_q);
						mul_b   = mag32(sd_q);
						mul_neg = 1'b0;
					end
					2'd1: begin
						mul_a   = mag32(sl_q);
						mul_b   = mag32(sl_q);
						mul_neg = 1'b0;
					end
					2'd2: begin
						mul_a   = mag32(c1_q);
						mul_b   = mag32(c2_q);
						mul_neg = c1_q[CW-1] ^ c2_q[CW-1];
					end
					default: begin
						mul_a   = mag32(c12_q);
						mul_b   = mag32(slsl_q);
						mul_neg = c12_q[CW-1] ^ slsl_q[CW-1];
					end
				endcase
			end
			ST_SCALE: begin
				mul_a   = z_q[31:0];
				mul_b   = {1'b0, r200};
				mul_neg = 1'b0;
			end
			default: ;
		endcase
	end
	assign prod_d = mul_a * mul_b;

	// round half up on the registered product, then apply sign
	logic [64:0]          rnd_sum_lo, rnd_sum_hi;
	logic [RW-1:0]        rnd_mag;
	logic signed [CW-1:0] rnd_pos, rnd_val;
	logic                 use_hi;
	assign use_hi     = (state_q == ST_RAD) && job_q[1];
	assign rnd_sum_lo = {1'b0, prod_q} + (65'd1 << (AFB - 1));
	assign rnd_sum_hi = {1'b0, prod_q} + (65'd1 << AFB);
	assign rnd_mag    = use_hi ? RW'(rnd_sum_hi >> (AFB + 1)) : RW'(rnd_sum_lo >> AFB);
	assign rnd_pos    = $signed(CW'(rnd_mag));
	assign rnd_val    = msign_q ? -rnd_pos : rnd_pos;

	// shared cordic step, rotation drives z to zero, vectoring drives y to zero
	logic                 cdir;
	logic signed [CW-1:0] cdx, cdy, cat, x_n, y_n, z_n;
	assign cdir = (state_q == ST_ROT) ? ~z_q[CW-1] : y_q[CW-1];
	assign cdx  = y_q >>> it_q;
	assign cdy  = x_q >>> it_q;
	assign cat  = $signed(CW'(gthd_pkg::atan_f(6'(it_q))));
	assign x_n  = cdir ? x_q - cdx : x_q + cdx;
	assign y_n  = cdir ? y_q + cdy : y_q - cdy;
	assign z_n  = cdir ? z_q - cat : z_q + cat;

	logic cordic_done;
	assign cordic_done = (it_q == ITW'(CORDIC_ITERATIONS));

	// haversine term sum, clamped to [0, 1]
	logic signed [CW:0] acc_sum;
	logic [AFB:0]       a_val;
	always_comb begin
		acc_sum = (CW+1)'(sdsd_q) + (CW+1)'(term_q);
		if (acc_sum[CW]) begin
			a_val = '0;
		end else if (acc_sum > (CW+1)'(gthd_pkg::ONE_F)) begin
			a_val = gthd_pkg::ONE_F;
		end else begin
			a_val = acc_sum[AFB:0];
		end
	end

	// digit-by-digit square root step
	logic [63:0] sq_rb;
	logic        sq_take;
	assign sq_rb   = {1'b0, sq_r_q} + {1'b0, sq_b_q};
	assign sq_take = {1'b0, sq_n_q} >= sq_rb;

	logic [AFB:0] one_minus_a;
	assign one_minus_a = gthd_pkg::ONE_F - a_q;

	// saturated distance
	logic [DW-1:0] dist_sat;
	assign dist_sat = (rnd_mag > RW'(gthd_pkg::DIST_MAX)) ? gthd_pkg::DIST_MAX : rnd_mag[DW-1:0];

	logic fix_beat, out_free;
	assign fix_ready = (state_q == ST_IDLE);
	assign fix_beat  = fix_valid && fix_ready;
	assign out_free  = !dist_valid_q || dist_ready;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			it_q         <= '0;
			job_q        <= '0;
			pass_q       <= 1'b0;
			has_prev_q   <= 1'b0;
			has_two_q    <= 1'b0;
			seen_q       <= '0;
			radius_q     <= gthd_pkg::RADIUS_RESET;
			dist_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
			// output beat raised from the last state, dropped once taken
			if (state_q == ST_OUT && out_free) begin
				dist_valid_q <= 1'b1;
			end else if (dist_valid_q && dist_ready) begin
				dist_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fix_beat) begin
						has_prev_q <= (seen_q != 2'd0);
						has_two_q  <= (seen_q == 2'd2);
						pass_q     <= 1'b0;
						job_q      <= 2'd0;
						it_q       <= '0;
						state_q    <= (seen_q != 2'd0) ? ST_RAD : ST_OUT;
					end
				end
				ST_RAD: begin
					if (it_q == ITW'(3)) begin
						it_q    <= '0;
						state_q <= ST_ROT;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_ROT: begin
					if (cordic_done) begin
						it_q <= '0;
						if (job_q == 2'd3) begin
							job_q   <= 2'd0;
							state_q <= ST_MUL;
						end else begin
							job_q   <= (pass_q && job_q == 2'd0) ? 2'd2 : job_q + 2'd1;
							state_q <= ST_RAD;
						end
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (it_q[0]) begin
						it_q <= '0;
						if (job_q == 2'd3) begin
							job_q   <= 2'd0;
							state_q <= ST_ACC;
						end else begin
							job_q <= job_q + 2'd1;
						end
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_ACC: begin
					job_q   <= 2'd0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_b_q == '0) begin
						if (job_q == 2'd0) begin
							job_q <= 2'd1;
						end else begin
							it_q    <= '0;
							state_q <= (sa_q == '0) ? ST_SCALE : ST_VEC;
						end
					end
				end
				ST_VEC: begin
					if (cordic_done) begin
						it_q    <= '0;
						state_q <= ST_SCALE;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_SCALE: begin
					if (it_q[0]) begin
						it_q <= '0;
						if (!pass_q && has_two_q) begin
							pass_q  <= 1'b1;
							job_q   <= 2'd0;
							state_q <= ST_RAD;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (seen_q != 2'd2) begin
							seen_q <= seen_q + 2'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (fix_beat) begin
					cur_lat_q <= lat_e7;
					cur_lon_q <= lon_e7;
					dprev_q   <= '0;
					dtwo_q    <= '0;
				end
			end
			ST_RAD: begin
				case (it_q[1:0])
					2'd0: begin
						prod_q  <= prod_d;
						msign_q <= mul_neg;
					end
					2'd1: z_q <= rnd_val;
					2'd2: begin
						if (z_q > gthd_pkg::PI_F) begin
							z_q <= z_q - gthd_pkg::TPI_F;
						end else if (z_q < -gthd_pkg::PI_F) begin
							z_q <= z_q + gthd_pkg::TPI_F;
						end
					end
					default: begin
						if (z_q > gthd_pkg::HPI_F) begin
							z_q    <= z_q - gthd_pkg::PI_F;
							rneg_q <= 1'b1;
						end else if (z_q < -gthd_pkg::HPI_F) begin
							z_q    <= z_q + gthd_pkg::PI_F;
							rneg_q <= 1'b1;
						end else begin
							rneg_q <= 1'b0;
						end
						x_q <= gthd_pkg::GAIN_F;
						y_q <= '0;
					end
				endcase
			end
			ST_ROT: begin
				if (cordic_done) begin
					case (job_q)
						2'd0:    c1_q <= rneg_q ? -x_q : x_q;
						2'd1:    c2_q <= rneg_q ? -x_q : x_q;
						2'd2:    sd_q <= rneg_q ? -y_q : y_q;
						default: sl_q <= rneg_q ? -y_q : y_q;
					endcase
				end else begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
				end
			end
			ST_MUL: begin
				if (!it_q[0]) begin
					prod_q  <= prod_d;
					msign_q <= mul_neg;
				end else begin
					case (job_q)
						2'd0:    sdsd_q <= rnd_val;
						2'd1:    slsl_q <= rnd_val;
						2'd2:    c12_q  <= rnd_val;
						default: term_q <= rnd_val;
					endcase
				end
			end
			ST_ACC: begin
				a_q    <= a_val;
				sq_n_q <= 63'(a_val) << (62 - AFB);
				sq_r_q <= '0;
				sq_b_q <= 63'(1) << 62;
			end
			ST_SQRT: begin
				if (sq_b_q != '0) begin
					if (sq_take) begin
						sq_n_q <= sq_n_q - sq_rb[62:0];
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
				end else if (job_q == 2'd0) begin
					sa_q   <= sq_r_q[31:0];
					sq_n_q <= 63'(one_minus_a) << (62 - AFB);
					sq_r_q <= '0;
					sq_b_q <= 63'(1) << 62;
				end else begin
					x_q <= $signed(CW'(sq_r_q[31:0]));
					y_q <= $signed(CW'(sa_q));
					z_q <= '0;
				end
			end
			ST_VEC: begin
				if (cordic_done) begin
					if (z_q[CW-1]) begin
						z_q <= '0;
					end
				end else begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
				end
			end
			ST_SCALE: begin
				if (!it_q[0]) begin
					prod_q  <= prod_d;
					msign_q <= 1'b0;
				end else if (pass_q) begin
					dtwo_q <= dist_sat;
				end else begin
					dprev_q <= dist_sat;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					dist_prev_cm_q        <= dprev_q;
					dist_prev_valid_q     <= has_prev_q;
					dist_two_back_cm_q    <= dtwo_q;
					dist_two_back_valid_q <= has_two_q;
					older_lat_q           <= last_lat_q;
					older_lon_q           <= last_lon_q;
					last_lat_q            <= cur_lat_q;
					last_lon_q            <= cur_lon_q;
				end
			end
			default: ;
		endcase
	end

	// output beat
	assign dist_valid          = dist_valid_q;
	assign dist_prev_cm        = dist_prev_cm_q;
	assign dist_prev_valid     = dist_prev_valid_q;
	assign dist_two_back_cm    = dist_two_back_cm_q;
	assign dist_two_back_valid = dist_two_back_valid_q;

	// checks
	a_busy_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && fix_ready |=> !fix_ready)
		else $error("block still ready after taking a fix");

	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> (!dist_two_back_valid || dist_prev_valid))
		else $error("two-back distance flagged without previous distance");

	a_zero_when_no_history: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && !dist_prev_valid |-> dist_prev_cm == '0 && dist_two_back_cm == '0)
		else $error("distance without history is not zero");

	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> dist_prev_cm <= gthd_pkg::DIST_MAX &&
			dist_two_back_cm <= gthd_pkg::DIST_MAX)
		else $error("distance beyond saturation limit");

	a_hav_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> a_q <= gthd_pkg::ONE_F)
		else $error("haversine term outside unit range");

	a_angle_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |-> !z_q[CW-1])
		else $error("negative central angle reached scaling");

endmodule
